// ----- sv/dhlt_pkg.sv -----
package dhlt_pkg;

  localparam int AngBits      = 16;
  localparam int TrigBits     = 16;
  localparam int LengthBitsDefault = 24;
  localparam int CordicIterDefault = 16;
  localparam int TableLen     = 24;
  localparam int CordicW      = 34;
  localparam logic signed [AngBits-1:0] HalfPiQ13 = 16'sd12868;
  localparam logic signed [AngBits-1:0] PiQ13     = 16'sd25736;
  localparam logic signed [TrigBits-1:0] Q14One   = 16'sd16384;
  localparam logic signed [CordicW-1:0] GainQ30   = 34'sh26DD3B6A;

  localparam int FixedLen = LengthBitsDefault;

  typedef struct packed {
    logic signed [AngBits-1:0]  joint_angle;
    logic signed [AngBits-1:0]  twist_angle;
    logic signed [FixedLen-1:0] link_length;
    logic signed [FixedLen-1:0] link_offset;
  } in_req_t;

  typedef struct packed {
    logic signed [TrigBits-1:0] m00;
    logic signed [TrigBits-1:0] m01;
    logic signed [TrigBits-1:0] m02;
    logic signed [FixedLen-1:0] trans_x;
    logic signed [TrigBits-1:0] m10;
    logic signed [TrigBits-1:0] m11;
    logic signed [TrigBits-1:0] m12;
    logic signed [FixedLen-1:0] trans_y;
    logic signed [TrigBits-1:0] m21;
    logic signed [TrigBits-1:0] m22;
    logic signed [FixedLen-1:0] trans_z;
  } out_req_t;

  function automatic logic signed [CordicW-1:0] atan_q30(input logic [4:0] idx);
    case (idx)
      5'd0:  atan_q30 = 34'sh3243F6A8;
      5'd1:  atan_q30 = 34'sh1DAC6705;
      5'd2:  atan_q30 = 34'sh0FADBAFC;
      5'd3:  atan_q30 = 34'sh07F56EA6;
      5'd4:  atan_q30 = 34'sh03FEAB76;
      5'd5:  atan_q30 = 34'sh01FFD55B;
      5'd6:  atan_q30 = 34'sh00FFFAAA;
      5'd7:  atan_q30 = 34'sh007FFF55;
      5'd8:  atan_q30 = 34'sh003FFFEA;
      5'd9:  atan_q30 = 34'sh001FFFFD;
      5'd10: atan_q30 = 34'sh000FFFFF;
      5'd11: atan_q30 = 34'sh0007FFFF;
      5'd12: atan_q30 = 34'sh0003FFFF;
      5'd13: atan_q30 = 34'sh0001FFFF;
      5'd14: atan_q30 = 34'sh0000FFFF;
      5'd15: atan_q30 = 34'sh00007FFF;
      5'd16: atan_q30 = 34'sh00003FFF;
      5'd17: atan_q30 = 34'sh00001FFF;
      5'd18: atan_q30 = 34'sh00000FFF;
      5'd19: atan_q30 = 34'sh000007FF;
      5'd20: atan_q30 = 34'sh000003FF;
      5'd21: atan_q30 = 34'sh000001FF;
      5'd22: atan_q30 = 34'sh000000FF;
      5'd23: atan_q30 = 34'sh0000007F;
      default: atan_q30 = '0;
    endcase
  endfunction

endpackage

// ----- sv/dhlt_cordic.sv -----
module dhlt_cordic #(
  parameter int ITERS = dhlt_pkg::CordicIterDefault
) (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic signed [dhlt_pkg::AngBits-1:0]    ang,
  output logic signed [dhlt_pkg::TrigBits-1:0]   sin_q14,
  output logic signed [dhlt_pkg::TrigBits-1:0]   cos_q14
);

  localparam int W = dhlt_pkg::CordicW;
  localparam int N = (ITERS > dhlt_pkg::TableLen) ? dhlt_pkg::TableLen : ITERS;
  localparam int ZPad = W - dhlt_pkg::AngBits - 17;

  logic signed [W-1:0] x_r [0:N];
  logic signed [W-1:0] y_r [0:N];
  logic signed [W-1:0] z_r [0:N];
  logic                neg_r [0:N];
  logic signed [dhlt_pkg::TrigBits-1:0] s_r, c_r;

  logic signed [dhlt_pkg::AngBits-1:0] red;
  logic                                fold;

  always_comb begin
    fold = 1'b0;
    red  = ang;
    if (ang > dhlt_pkg::HalfPiQ13) begin
      red  = ang - dhlt_pkg::PiQ13;
      fold = 1'b1;
    end else if (ang < -dhlt_pkg::HalfPiQ13) begin
      red  = ang + dhlt_pkg::PiQ13;
      fold = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= dhlt_pkg::GainQ30;
      y_r[0]   <= '0;
      z_r[0]   <= {{ZPad{red[dhlt_pkg::AngBits-1]}}, red, 17'd0};
      neg_r[0] <= fold;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_it
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][W-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - dhlt_pkg::atan_q30(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + dhlt_pkg::atan_q30(5'(i));
        end
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  function automatic logic signed [dhlt_pkg::TrigBits-1:0] to_q14(
    input logic signed [W-1:0] v, input logic neg);
    logic signed [W-1:0] r;
    logic signed [dhlt_pkg::TrigBits-1:0] q;
    r = (v + W'(32768)) >>> 16;
    if (r > W'(dhlt_pkg::Q14One)) q = dhlt_pkg::Q14One;
    else if (r < -W'(dhlt_pkg::Q14One)) q = -dhlt_pkg::Q14One;
    else q = r[dhlt_pkg::TrigBits-1:0];
    return neg ? -q : q;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= to_q14(x_r[N], neg_r[N]);
      s_r <= to_q14(y_r[N], neg_r[N]);
    end
  end

  assign sin_q14 = s_r;
  assign cos_q14 = c_r;

endmodule

// ----- sv/dh_link_transform_core.sv -----
// dh_link_transform_core: denavit-hartenberg link transform
// input channel in_valid/in_ready/in_data carries theta, alpha (q2.13), a and d
// output channel out_valid/out_ready/out_data carries the eleven variable
// entries of the homogeneous link transform, row-major, bottom row implied
// both angles go through a fully pipelined cordic, one stage per iteration,
// then one product stage and one rounding/saturation stage
// throughput: one request per cycle while out_ready is high
// the whole pipeline advances together; when out_ready is low and the output
// register is full, the pipeline freezes and in_ready drops, nothing is lost
// reset clears all valid bits; payload registers are not reset
module dh_link_transform_core #(
  parameter int CORDIC_ITERATIONS = dhlt_pkg::CordicIterDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dhlt_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dhlt_pkg::out_req_t out_data
);

  localparam int N   = (CORDIC_ITERATIONS > dhlt_pkg::TableLen) ?
                       dhlt_pkg::TableLen : CORDIC_ITERATIONS;
  localparam int CL  = N + 2;
  localparam int LB  = dhlt_pkg::FixedLen;
  localparam int TB  = dhlt_pkg::TrigBits;
  localparam int PW  = LB + TB + 1;
  localparam int TW  = 2 * TB + 1;
  localparam logic signed [PW-1:0] LenMax = PW'({1'b0, {(LB-1){1'b1}}});
  localparam logic signed [PW-1:0] LenMin = ~LenMax;

  logic        adv;
  logic [CL+1:0] vld_r;
  logic signed [LB-1:0] a_r [0:CL-1];
  logic signed [LB-1:0] d_r [0:CL-1];
  logic signed [TB-1:0] st, ct, sa, ca;

  assign adv      = !vld_r[CL+1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld_r[CL+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[CL:0], in_valid};
    end
  end

  dhlt_cordic #(.ITERS(N)) u_theta (
    .clk(clk), .en(adv), .ang(in_data.joint_angle), .sin_q14(st), .cos_q14(ct)
  );
  dhlt_cordic #(.ITERS(N)) u_alpha (
    .clk(clk), .en(adv), .ang(in_data.twist_angle), .sin_q14(sa), .cos_q14(ca)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r[0] <= in_data.link_length;
      d_r[0] <= in_data.link_offset;
      for (int k = 1; k < CL; k++) begin
        a_r[k] <= a_r[k-1];
        d_r[k] <= d_r[k-1];
      end
    end
  end

  // product stage
  logic signed [TW-1:0] p01_r, p02_r, p11_r, p12_r;
  logic signed [PW-1:0] px_r, py_r;
  logic signed [TB-1:0] st_r, ct_r, sa_r, ca_r;
  logic signed [LB-1:0] dz_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p01_r <= TW'(-st) * TW'(ca);
      p02_r <= TW'(st) * TW'(sa);
      p11_r <= TW'(ct) * TW'(ca);
      p12_r <= TW'(-ct) * TW'(sa);
      px_r  <= PW'(a_r[CL-1]) * PW'(ct);
      py_r  <= PW'(a_r[CL-1]) * PW'(st);
      st_r <= st; ct_r <= ct; sa_r <= sa; ca_r <= ca;
      dz_r <= d_r[CL-1];
    end
  end

  function automatic logic signed [TB-1:0] rnd_t(input logic signed [TW-1:0] p);
    logic signed [TW-1:0] r;
    r = (p + TW'(8192)) >>> 14;
    return r[TB-1:0];
  endfunction

  function automatic logic signed [LB-1:0] rnd_l(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] r;
    r = (p + PW'(8192)) >>> 14;
    if (r > LenMax) return LenMax[LB-1:0];
    if (r < LenMin) return LenMin[LB-1:0];
    return r[LB-1:0];
  endfunction

  dhlt_pkg::out_req_t out_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.m00     <= ct_r;
      out_r.m01     <= rnd_t(p01_r);
      out_r.m02     <= rnd_t(p02_r);
      out_r.trans_x <= rnd_l(px_r);
      out_r.m10     <= st_r;
      out_r.m11     <= rnd_t(p11_r);
      out_r.m12     <= rnd_t(p12_r);
      out_r.trans_y <= rnd_l(py_r);
      out_r.m21     <= sa_r;
      out_r.m22     <= ca_r;
      out_r.trans_z <= dz_r;
    end
  end

  assign out_data = out_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed under stall");
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline frozen");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("valid bits moved while frozen");
  a_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.m00 <= dhlt_pkg::Q14One && out_data.m00 >= -dhlt_pkg::Q14One)
    else $error("cosine out of range");

endmodule
